// ----- src/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_APPEND       = 2'd0,
		CMD_REMOVE_LAST  = 2'd1,
		CMD_REMOVE_VALUE = 2'd2,
		CMD_DUMP         = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] item_value;
		logic [4:0]         entry_count;
		logic               found;
		logic               full_reject;
		logic               empty_flag;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

// ----- src/ole_ram.sv -----
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/ole_seq.sv -----
// ----------------------------------------------------------------------------
// ole_seq
// Command sequencer: count register, list walk over the entry RAM with
// in-place gap closing, and result generation.
// ----------------------------------------------------------------------------
module ole_seq
	import ole_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	output logic              busy,
	output mem_req_t          mem_req,
	input  logic [DATA_W-1:0] rdata,
	output logic              res_valid,
	output rsp_t              res
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rd_q, rd_d;
	logic             found_q, found_d;
	logic [1:0]       cmd_q, cmd_d;
	logic [31:0]      val_q, val_d;
	logic             v_s1, v_d;
	logic [IDX_W-1:0] idx_s1, idx_d;

	logic accept;
	logic is_last;
	logic match;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign is_last = v_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q);
	assign match   = (rdata == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			found_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_q    <= rd_d;
			found_q <= found_d;
			v_s1    <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		val_q  <= val_d;
		idx_s1 <= idx_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (count_q != '0) &&
				    ((req.command == CMD_REMOVE_VALUE) || (req.command == CMD_DUMP))) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (is_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// datapath and outputs
	always_comb begin
		mem_req   = '0;
		res_valid = 1'b0;
		res       = '0;
		count_d   = count_q;
		rd_d      = rd_q;
		found_d   = found_q;
		cmd_d     = cmd_q;
		val_d     = val_q;
		v_d       = 1'b0;
		idx_d     = rd_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.command) inside
						CMD_APPEND: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (count_q == CNT_W'(CAPACITY)) begin
								res.full_reject = 1'b1;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q[IDX_W-1:0];
								mem_req.wdata = req.value;
								count_d       = count_q + CNT_W'(1);
							end
						end
						CMD_REMOVE_LAST: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (count_q != '0) begin
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_REMOVE_VALUE, CMD_DUMP: begin
							if (count_q == '0) begin
								res_valid = 1'b1;
								res.last  = 1'b1;
							end else begin
								rd_d    = '0;
								found_d = 1'b0;
								cmd_d   = req.command;
								val_d   = req.value;
							end
						end
					endcase
				end
			end
			ST_WALK: begin
				if (rd_q < count_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_q[IDX_W-1:0];
					rd_d          = rd_q + CNT_W'(1);
					v_d           = 1'b1;
				end
				if (v_s1) begin
					if (cmd_q == CMD_DUMP) begin
						res_valid      = 1'b1;
						res.item_value = rdata;
						res.last       = is_last;
					end else begin
						if (found_q) begin
							// close the gap: entry moves down one place
							mem_req.we    = 1'b1;
							mem_req.waddr = idx_s1 - IDX_W'(1);
							mem_req.wdata = rdata;
						end else if (match) begin
							found_d = 1'b1;
						end
						if (is_last) begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							res.found = found_q || match;
							if (found_q || match) begin
								count_d = count_q - CNT_W'(1);
							end
						end
					end
				end
			end
		endcase
		res.entry_count = 5'(count_d);
		res.empty_flag  = (count_d == '0);
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held count above capacity");

	a_no_idle_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_req.re && !v_s1)
		else $error("RAM read while idle");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("read and write to one entry in one cycle");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((req.command == CMD_APPEND) || (req.command == CMD_REMOVE_LAST)))
		|-> (res_valid && res.last) ##1 (state_q == ST_IDLE))
		else $error("single-result command did not complete at once");
`endif

endmodule

// ----- src/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values held in a synchronous RAM.
// ----------------------------------------------------------------------------
// An item is accepted on a rising edge with start high and busy low. Append
// and remove-last never raise busy: one item per cycle, result in the
// following cycle. Remove-value and dump on an empty list finish the same
// way. On a list of n entries, n at least one, they walk the RAM through its
// single read port with registered read data: busy stays high until the last
// entry has been read, and no new item is taken before then. Dump results
// come one per cycle; results cannot be stalled and each is valid for
// exactly the one cycle that strobe is high.
module ordered_list_engine
	import ole_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	output logic  busy,
	output logic  strobe,
	output rsp_t  rsp
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rdata;
	logic              res_valid;
	rsp_t              res;
	logic              strobe_q;
	rsp_t              rsp_q;

	ole_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(rdata)
	);

	ole_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.mem_req  (mem_req),
		.rdata    (rdata),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule
